/* src/tsr_pkg.sv */
package tsr_pkg;

  localparam int MAX_CONTESTANTS = 64;
  localparam int SCORE_BITS      = 10;

  localparam int IDX_BITS    = $clog2(MAX_CONTESTANTS);
  localparam int CNT_BITS    = $clog2(MAX_CONTESTANTS + 1);
  localparam int JUDGE_BITS  = 8;
  localparam int NCONT_BITS  = 7;
  localparam int SUM_BITS    = SCORE_BITS + JUDGE_BITS;
  localparam int EDGE_BITS   = SCORE_BITS + 1;
  localparam int TOTAL_BITS  = 20;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CONTESTANTS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_JUDGES      = 2'd1;

  // table write and round hand-off from accumulator to ranker
  typedef struct packed {
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [TOTAL_BITS-1:0] wr_data;
    logic                  round_done;
    logic [CNT_BITS-1:0]   round_n;
  } acc_to_rank_t;

endpackage

/* src/tsr_accum.sv */
module tsr_accum import tsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [SCORE_BITS-1:0] score,
  input  logic [JUDGE_BITS-1:0] num_judges,
  input  logic [CNT_BITS-1:0]   n_eff,
  output logic                  busy,
  output acc_to_rank_t          to_rank
);

  logic [SCORE_BITS-1:0] score_q;
  logic                  proc;
  logic [SUM_BITS-1:0]   run_sum;
  logic [SCORE_BITS-1:0] run_min;
  logic [SCORE_BITS-1:0] run_max;
  logic [JUDGE_BITS-1:0] judge_count;
  logic                  second_category;
  logic [CNT_BITS-1:0]   contestant_count;
  logic [TOTAL_BITS-1:0] first_total;

  logic [SUM_BITS-1:0]   sum_next;
  logic [SCORE_BITS-1:0] min_next;
  logic [SCORE_BITS-1:0] max_next;
  logic [JUDGE_BITS-1:0] count_next;
  logic [EDGE_BITS-1:0]  edge_sum;
  logic [SUM_BITS-1:0]   trimmed;
  logic                  cat_done;
  logic [IDX_BITS-1:0]   idx;
  logic [CNT_BITS-1:0]   idx_plus;
  logic                  round_end;

  // running statistics including the held score
  always_comb begin
    sum_next   = run_sum + SUM_BITS'(score_q);
    min_next   = (score_q < run_min) ? score_q : run_min;
    max_next   = (score_q > run_max) ? score_q : run_max;
    count_next = judge_count + JUDGE_BITS'(1);
    cat_done   = (count_next == '0) || (count_next >= num_judges);
    edge_sum   = EDGE_BITS'(min_next) + EDGE_BITS'(max_next);
    trimmed    = (sum_next > SUM_BITS'(edge_sum)) ? (sum_next - SUM_BITS'(edge_sum)) : '0;
  end

  // table slot of the current contestant
  always_comb begin
    if (contestant_count >= CNT_BITS'(MAX_CONTESTANTS)) begin
      idx = IDX_BITS'(MAX_CONTESTANTS - 1);
    end else begin
      idx = contestant_count[IDX_BITS-1:0];
    end
    idx_plus  = CNT_BITS'(idx) + CNT_BITS'(1);
    round_end = proc && cat_done && second_category && !(idx_plus < n_eff);
  end

  // table write on each finished category
  always_comb begin
    to_rank.wr_en      = proc && cat_done;
    to_rank.wr_addr    = idx;
    to_rank.wr_data    = second_category ? (first_total + TOTAL_BITS'(trimmed))
                                         : TOTAL_BITS'(trimmed);
    to_rank.round_done = round_end;
    to_rank.round_n    = n_eff;
  end

  assign busy = proc;

  // score folding and category sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      proc             <= 1'b0;
      run_sum          <= '0;
      run_min          <= '1;
      run_max          <= '0;
      judge_count      <= '0;
      second_category  <= 1'b0;
      contestant_count <= '0;
    end else begin
      proc <= accept;
      if (proc) begin
        if (!cat_done) begin
          run_sum     <= sum_next;
          run_min     <= min_next;
          run_max     <= max_next;
          judge_count <= count_next;
        end else begin
          run_sum     <= '0;
          run_min     <= '1;
          run_max     <= '0;
          judge_count <= '0;
          if (!second_category) begin
            second_category <= 1'b1;
          end else begin
            second_category <= 1'b0;
            if (idx_plus < n_eff) begin
              contestant_count <= idx_plus;
            end else begin
              contestant_count <= '0;
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      score_q <= score;
    end
    if (proc && cat_done && !second_category) begin
      first_total <= TOTAL_BITS'(trimmed);
    end
  end

endmodule

/* src/tsr_rank.sv */
module tsr_rank import tsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  acc_to_rank_t          from_acc,
  output logic                  busy,
  output logic                  strobe,
  output logic [IDX_BITS-1:0]   contestant,
  output logic [TOTAL_BITS-1:0] total,
  output logic                  last
);

  typedef enum logic [1:0] {
    R_IDLE,
    R_SCAN,
    R_DRAIN
  } rank_state_t;

  rank_state_t state;

  logic [TOTAL_BITS-1:0]      totals_mem [MAX_CONTESTANTS];
  logic [TOTAL_BITS-1:0]      rd_data;
  logic [IDX_BITS-1:0]        rd_addr;
  logic [IDX_BITS-1:0]        addr_q;
  logic                       rd_valid_q;
  logic [TOTAL_BITS-1:0]      best;
  logic [IDX_BITS-1:0]        best_idx;
  logic                       found;
  logic [IDX_BITS-1:0]        rank;
  logic [CNT_BITS-1:0]        n_q;
  logic [MAX_CONTESTANTS-1:0] emitted;

  logic                       take;
  logic [TOTAL_BITS-1:0]      cand_total;
  logic [IDX_BITS-1:0]        cand_idx;
  logic                       last_addr;
  logic                       last_rank;

  // totals table: one write port, registered read
  always_ff @(posedge clk) begin
    if (from_acc.wr_en) begin
      totals_mem[from_acc.wr_addr] <= from_acc.wr_data;
    end
    rd_data <= totals_mem[rd_addr];
  end

  // shared compare: strictly greater keeps the earliest index on ties
  always_comb begin
    take       = rd_valid_q && !emitted[addr_q] && (!found || (rd_data > best));
    cand_total = take ? rd_data : best;
    cand_idx   = take ? addr_q : best_idx;
    last_addr  = (CNT_BITS'(rd_addr) == (n_q - CNT_BITS'(1)));
    last_rank  = (CNT_BITS'(rank) == (n_q - CNT_BITS'(1)));
  end

  assign busy = (state != R_IDLE);

  // scan sequencer: one pass over the table per rank
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= R_IDLE;
      rd_addr    <= '0;
      rd_valid_q <= 1'b0;
      found      <= 1'b0;
      rank       <= '0;
      n_q        <= CNT_BITS'(1);
      emitted    <= '0;
      strobe     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      rd_valid_q <= 1'b0;
      addr_q     <= rd_addr;
      case (state)
        R_IDLE: begin
          if (from_acc.round_done) begin
            state   <= R_SCAN;
            n_q     <= from_acc.round_n;
            rd_addr <= '0;
            rank    <= '0;
            found   <= 1'b0;
            emitted <= '0;
          end
        end
        R_SCAN: begin
          rd_valid_q <= 1'b1;
          best       <= cand_total;
          best_idx   <= cand_idx;
          found      <= found || take;
          if (last_addr) begin
            state <= R_DRAIN;
          end else begin
            rd_addr <= rd_addr + IDX_BITS'(1);
          end
        end
        R_DRAIN: begin
          strobe             <= 1'b1;
          contestant         <= cand_idx;
          total              <= cand_total;
          last               <= last_rank;
          emitted[cand_idx]  <= 1'b1;
          found              <= 1'b0;
          rd_addr            <= '0;
          rank               <= rank + IDX_BITS'(1);
          if (last_rank) begin
            state <= R_IDLE;
          end else begin
            state <= R_SCAN;
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/trimmed_score_ranking_unit.sv */
// Judge scores go in one per start pulse while busy is low. Each accepted score
// is folded into the running sum, minimum and maximum in the cycle after it is
// taken; busy is high while it is folded, so no new score is taken then. After
// the last score of the last contestant the block ranks the stored totals,
// highest first and equal totals in arrival order: for each rank one read pass
// over the totals memory picks the best remaining entry through a single
// comparator, and busy stays high until the whole round is ranked. Each ranked
// item appears on contestant, total and last for exactly one cycle with strobe
// high; the receiver cannot stall, so it must take every strobed item.
// Configuration writes are taken at any time but are meant to be made only
// while the block is idle.
module trimmed_score_ranking_unit import tsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [SCORE_BITS-1:0]    score,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     strobe,
  output logic [IDX_BITS-1:0]      contestant,
  output logic [TOTAL_BITS-1:0]    total,
  output logic                     last
);

  logic [NCONT_BITS-1:0] num_contestants;
  logic [JUDGE_BITS-1:0] num_judges;
  logic [CNT_BITS-1:0]   n_eff;
  logic                  accept;
  logic                  acc_busy;
  logic                  rank_busy;
  acc_to_rank_t          acc_to_rank;

  assign cfg_ready = 1'b1;
  assign busy      = acc_busy || rank_busy;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_contestants <= NCONT_BITS'(1);
      num_judges      <= JUDGE_BITS'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_CONTESTANTS: num_contestants <= cfg_data[NCONT_BITS-1:0];
        REG_NUM_JUDGES:      num_judges      <= cfg_data[JUDGE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // contestant count clamped to the table size, zero taken as one
  always_comb begin
    if (num_contestants == '0) begin
      n_eff = CNT_BITS'(1);
    end else if (32'(num_contestants) > MAX_CONTESTANTS) begin
      n_eff = CNT_BITS'(MAX_CONTESTANTS);
    end else begin
      n_eff = CNT_BITS'(num_contestants);
    end
  end

  tsr_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .score      (score),
    .num_judges (num_judges),
    .n_eff      (n_eff),
    .busy       (acc_busy),
    .to_rank    (acc_to_rank)
  );

  tsr_rank u_rank (
    .clk        (clk),
    .rst        (rst),
    .from_acc   (acc_to_rank),
    .busy       (rank_busy),
    .strobe     (strobe),
    .contestant (contestant),
    .total      (total),
    .last       (last)
  );

endmodule

/* sim/tb_trimmed_score_ranking_unit.sv */
`timescale 1ns / 1ps

module tb_trimmed_score_ranking_unit;
  import tsr_pkg::*;

  // index codes that map to no register
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_3 = 2'd3;

  // score styles for random rounds
  localparam int STYLE_FULL    = 0;
  localparam int STYLE_NARROW  = 1;
  localparam int STYLE_EXTREME = 2;
  localparam int STYLE_TOP     = 3;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_SCORES = 16;

  typedef struct packed {
    logic [IDX_BITS-1:0]   contestant;
    logic [TOTAL_BITS-1:0] total;
    logic                  last;
  } rank_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [SCORE_BITS-1:0]    score = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_NUM_CONTESTANTS;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     strobe;
  logic [IDX_BITS-1:0]      contestant;
  logic [TOTAL_BITS-1:0]    total;
  logic                     last;

  trimmed_score_ranking_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .score      (score),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .contestant (contestant),
    .total      (total),
    .last       (last)
  );

  // pending scores and ranks still to come out
  logic [SCORE_BITS-1:0] score_queue[$];
  rank_t                 ranks_due[$];

  int sender_idle = 13;
  int errors = 0;
  int scores_taken = 0;
  int ranks_checked = 0;
  int rounds_ranked = 0;
  int cfg_writes = 0;
  int cycles = 0;

  // shadow of the scoring state
  logic [NCONT_BITS-1:0] reg_ncont = 7'd1;
  logic [JUDGE_BITS-1:0] reg_judges = 8'd3;
  logic [SUM_BITS-1:0]   acc_sum = '0;
  logic [SCORE_BITS-1:0] acc_min = '1;
  logic [SCORE_BITS-1:0] acc_max = '0;
  logic [JUDGE_BITS-1:0] acc_count = '0;
  logic                  in_second = 1'b0;
  logic [NCONT_BITS-1:0] cur_idx = '0;
  logic [TOTAL_BITS-1:0] totals [MAX_CONTESTANTS];

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_contestants();
    if (reg_ncont == 0) return 1;
    if (reg_ncont > MAX_CONTESTANTS) return MAX_CONTESTANTS;
    return reg_ncont;
  endfunction

  // stable descending ranking of the first n totals
  function automatic void rank_round(int unsigned n);
    int unsigned order [MAX_CONTESTANTS];
    int unsigned key;
    int unsigned j;
    rank_t r;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = 1; i < n; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && totals[order[j-1]] < totals[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (int i = 0; i < n; i++) begin
      r.contestant = order[i][IDX_BITS-1:0];
      r.total      = totals[order[i]];
      r.last       = (i + 1 == n);
      ranks_due.push_back(r);
    end
    rounds_ranked++;
  endfunction

  // fold one accepted score, rank when the round closes
  function automatic void fold_score(logic [SCORE_BITS-1:0] s);
    int unsigned n;
    int unsigned edge_sum;
    int unsigned trimmed;
    int unsigned idx;
    n = eff_contestants();
    acc_sum = acc_sum + s;
    if (s < acc_min) acc_min = s;
    if (s > acc_max) acc_max = s;
    acc_count = acc_count + 1'b1;
    if (acc_count != 0 && acc_count < reg_judges) return;

    // category complete
    edge_sum = acc_min + acc_max;
    trimmed = (acc_sum > edge_sum) ? acc_sum - edge_sum : 0;
    acc_sum = '0;
    acc_min = '1;
    acc_max = '0;
    acc_count = '0;
    idx = (cur_idx >= MAX_CONTESTANTS) ? MAX_CONTESTANTS - 1 : cur_idx;
    if (!in_second) begin
      totals[idx] = trimmed[TOTAL_BITS-1:0];
      in_second = 1'b1;
      return;
    end
    totals[idx] = totals[idx] + trimmed[TOTAL_BITS-1:0];
    in_second = 1'b0;
    if (idx + 1 < n) begin
      cur_idx = NCONT_BITS'(idx + 1);
      return;
    end
    cur_idx = '0;
    rank_round(n);
  endfunction

  // scores needed to close the round from the given position
  function automatic int unsigned scores_left(int unsigned cnt, bit second, int unsigned idx);
    int unsigned n;
    int unsigned jeff;
    int unsigned rem;
    n = eff_contestants();
    jeff = (reg_judges < 2) ? 1 : reg_judges;
    rem = (cnt + 1 >= jeff) ? 1 : jeff - cnt;
    if (!second) rem += jeff;
    if (idx > MAX_CONTESTANTS - 1) idx = MAX_CONTESTANTS - 1;
    if (idx + 1 < n) rem += (n - 1 - idx) * 2 * jeff;
    return rem;
  endfunction

  function automatic logic [SCORE_BITS-1:0] pick_score(int style);
    case (style)
      STYLE_NARROW:  return SCORE_BITS'($urandom_range(3));
      STYLE_EXTREME: return $urandom_range(1) ? 10'd1023 : 10'd0;
      STYLE_TOP:     return 10'd1020 + SCORE_BITS'($urandom_range(3));
      default:       return SCORE_BITS'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [NCONT_BITS-1:0] pick_ncont();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 7'd0;
    if (roll == 1) return NCONT_BITS'($urandom_range(9, 16));
    return NCONT_BITS'($urandom_range(1, 8));
  endfunction

  function automatic logic [JUDGE_BITS-1:0] pick_judges();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return JUDGE_BITS'($urandom_range(1));
    if (roll == 1) return JUDGE_BITS'($urandom_range(6, 8));
    return JUDGE_BITS'($urandom_range(2, 5));
  endfunction

  // score driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        fold_score(score);
        scores_taken++;
      end
      if (!start || !busy) begin
        if (score_queue.size() != 0 && $urandom_range(99) >= sender_idle) begin
          start <= 1'b1;
          score <= score_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ranked item monitor
  always @(posedge clk) begin
    rank_t head;
    if (!rst && strobe) begin
      if (ranks_due.size() == 0) begin
        $error("unexpected item: contestant %0d total %0d last %0d", contestant, total, last);
        errors++;
      end else begin
        head = ranks_due.pop_front();
        if (contestant !== head.contestant) begin
          $error("contestant: expected %0d, got %0d", head.contestant, contestant);
          errors++;
        end
        if (total !== head.total) begin
          $error("total: expected %0d, got %0d", head.total, total);
          errors++;
        end
        if (last !== head.last) begin
          $error("last: expected %0d, got %0d", head.last, last);
          errors++;
        end
        ranks_checked++;
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("trimmed_score_ranking_unit regression: fail");
      $finish;
    end
  end

  task automatic push_scores(int unsigned count, int style);
    for (int i = 0; i < count; i++) score_queue.push_back(pick_score(style));
  endtask

  // wait until every score is folded and every rank has come out
  task automatic settle();
    while (score_queue.size() != 0 || start || busy || ranks_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_CONTESTANTS) reg_ncont = data[NCONT_BITS-1:0];
    else if (idx == REG_NUM_JUDGES) reg_judges = data;
    cfg_writes++;
  endtask

  initial begin
    int unsigned left;
    int unsigned part;
    int unsigned pushed;
    int style;
    bit synced;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default setup: one contestant, three judges, extreme and middle scores
    score_queue = '{10'd0, 10'd1023, 10'd512, 10'd1023, 10'd1023, 10'd1023};
    settle();

    // zero contestants acts as one, zero judges trims every score away
    write_reg(REG_NUM_CONTESTANTS, 8'd0);
    write_reg(REG_NUM_JUDGES, 8'd0);
    score_queue = '{10'd1023, 10'd0};
    settle();

    // single judge, three contestants all tied at zero
    write_reg(REG_NUM_CONTESTANTS, 8'd3);
    write_reg(REG_NUM_JUDGES, 8'd1);
    write_reg(REG_UNUSED_2, 8'hff);
    write_reg(REG_UNUSED_3, 8'h5a);
    score_queue = '{10'd1023, 10'd0, 10'd1, 10'd512, 10'd1022, 10'd1};
    settle();

    // judges lowered mid-category, contestants lowered mid-round
    write_reg(REG_NUM_CONTESTANTS, 8'd127);
    write_reg(REG_NUM_JUDGES, 8'd255);
    score_queue = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
    settle();
    write_reg(REG_NUM_JUDGES, 8'd2);
    score_queue = '{10'd1023, 10'd1023, 10'd0};
    settle();
    write_reg(REG_NUM_CONTESTANTS, 8'h81);
    score_queue = '{10'd7, 10'd9, 10'd1023, 10'd0};
    settle();

    // random rounds in three idle phases
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle = (phase == 0) ? 13 : (phase == 1) ? 69 : 0;
      settle();
      synced = 1'b1;
      pushed = 0;
      while (pushed < PHASE_SCORES) begin
        style = $urandom_range(3);
        if ($urandom_range(3) == 0) begin
          settle();
          write_reg(REG_NUM_CONTESTANTS, {1'($urandom_range(1)), pick_ncont()});
          synced = 1'b1;
        end
        if ($urandom_range(3) == 0) begin
          settle();
          write_reg(REG_NUM_JUDGES, pick_judges());
          synced = 1'b1;
        end
        left = synced ? scores_left(acc_count, in_second, cur_idx) : scores_left(0, 0, 0);
        synced = 1'b0;
        if (left > 1 && $urandom_range(7) == 0) begin
          // broken round: judge count changes part way through
          part = $urandom_range(1, left - 1);
          push_scores(part, style);
          pushed += part;
          settle();
          write_reg(REG_NUM_JUDGES, CFG_DATA_BITS'($urandom_range(2, 6)));
          synced = 1'b1;
        end else begin
          push_scores(left, style);
          pushed += left;
        end
      end

      // one closing round per phase
      settle();
      case (phase)
        0: begin
          // full table, every total tied at zero
          write_reg(REG_NUM_CONTESTANTS, 8'd127);
          write_reg(REG_NUM_JUDGES, 8'd0);
          push_scores(scores_left(acc_count, in_second, cur_idx), STYLE_NARROW);
        end
        1: begin
          // widest category, then finish with three judges
          write_reg(REG_NUM_CONTESTANTS, 8'd1);
          write_reg(REG_NUM_JUDGES, 8'd255);
          push_scores(255, STYLE_TOP);
          settle();
          write_reg(REG_NUM_JUDGES, 8'd3);
          push_scores(scores_left(acc_count, in_second, cur_idx), STYLE_FULL);
        end
        default: begin
          // short round of extreme scores
          write_reg(REG_NUM_CONTESTANTS, 8'd2);
          write_reg(REG_NUM_JUDGES, 8'd4);
          push_scores(scores_left(acc_count, in_second, cur_idx), STYLE_EXTREME);
        end
      endcase
    end

    settle();
    $display("%0d scores taken, %0d ranked items checked over %0d rounds", scores_taken,
             ranks_checked, rounds_ranked);
    $display("%0d register writes, contestants 0 to 127 and judges 0 to 255", cfg_writes);
    if (errors == 0) begin
      $display("trimmed_score_ranking_unit regression: pass");
    end else begin
      $display("trimmed_score_ranking_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/tsr_pkg.sv
src/tsr_accum.sv
src/tsr_rank.sv
src/trimmed_score_ranking_unit.sv
sim/tb_trimmed_score_ranking_unit.sv
